// File: sv/tcw_pkg.sv
package tcw_pkg;

    // Grid geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int COL_W   = $clog2(COLUMNS + 1);  // column must hold COLUMNS (wrap pending)
    localparam int ROW_W   = (ROWS > 2) ? $clog2(ROWS) : 1;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] BLANK_CODE   = 8'd32;
    localparam logic [7:0] RESET_ATTR   = 8'h0F;
    localparam logic [3:0] FG_RESET     = 4'd15;
    localparam logic [3:0] BG_RESET     = 4'd0;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [4:0]        row_field_t;
    typedef logic [6:0]        col_field_t;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FOREGROUND = 1'b0,
        REG_BACKGROUND = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        op_t        operation;
        logic [7:0] char_code;
        row_field_t read_row;
        col_field_t read_col;
    } request_t;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
        row_field_t cursor_row;
        col_field_t cursor_col;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic latch;       // capture request
        logic lf_advance;  // next row, column 0
        logic home_x;      // column 0 only (scroll case)
        logic home;        // row 0, column 0
        logic put_write;   // write char at cursor, advance column
        logic idx_clear;   // sweep index to 0
        logic copy_read;   // read cell one row below sweep index
        logic copy_write;  // write fetched cell at sweep index, step
        logic fill_write;  // write blank at sweep index, step
        logic fill_reset;  // blank uses reset attribute
        logic read_issue;  // read requested cell
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        op_t  operation;
        logic is_newline;
        logic need_wrap;
        logic last_row;
        logic copy_last;
        logic fill_last;
    } dp_status_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECIDE,
        ST_SCROLL_RD,
        ST_SCROLL_WR,
        ST_SCROLL_FILL,
        ST_CLEAR_FILL,
        ST_WRITE,
        ST_READ,
        ST_DONE
    } state_t;

endpackage

// File: sv/text_console_writer_unit.sv
// Channel  | Ports                               | Beat taken when
// ---------+-------------------------------------+----------------------------
// request  | start, busy, request                | start high, busy low
// result   | done, result                        | done high (one cycle only)
// config   | cfg_we, cfg_index, cfg_data         | cfg_we high
//
// A clear writes a blank into all cells, one cell per cycle. A newline or
//   wrap on the last row scrolls: each moved cell is read, then written back
//   one row up, and then each blank cell of the new bottom row is written.
// Reset: cursor homes and a clearing pass writes the reset blank into all
//   2000 cells, one per cycle; busy stays high through the pass.
//   Register writes are taken during the pass.
// done lasts one cycle and the receiver cannot stall it; busy is high from
//   the cycle after the accepted beat through the done cycle.
module text_console_writer_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  tcw_pkg::request_t              request,
    output logic                           done,
    output tcw_pkg::result_t               result,
    input  logic                           cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data
);

    tcw_pkg::dp_cmd_t    dp_cmd;
    tcw_pkg::dp_status_t dp_status;

    // sequencing: init sweep, put/wrap/scroll, clear sweep, read
    tcw_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (dp_status),
        .cmd    (dp_cmd),
        .busy   (busy),
        .done   (done)
    );

    // cursor, color registers, sweep index and the cell store
    tcw_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (dp_cmd),
        .status    (dp_status),
        .result    (result)
    );

endmodule

// File: sv/tcw_ctrl.sv
module tcw_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  tcw_pkg::dp_status_t status,
    output tcw_pkg::dp_cmd_t    cmd,
    output logic                busy,
    output logic                done
);

    tcw_pkg::state_t state_reg;
    tcw_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcw_pkg::ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        done       = 1'b0;
        case (state_reg)
            tcw_pkg::ST_INIT:
            begin
                cmd.fill_write = 1'b1;
                cmd.fill_reset = 1'b1;
                if (status.fill_last)
                begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = tcw_pkg::ST_DECIDE;
                end
            end
            tcw_pkg::ST_DECIDE:
            begin
                case (status.operation)
                    tcw_pkg::OP_PUT:
                    begin
                        if (status.is_newline || status.need_wrap)
                        begin
                            if (status.last_row)
                            begin
                                cmd.home_x    = 1'b1;
                                cmd.idx_clear = 1'b1;
                                state_next    = tcw_pkg::ST_SCROLL_RD;
                            end
                            else
                            begin
                                cmd.lf_advance = 1'b1;
                                state_next = status.is_newline ? tcw_pkg::ST_DONE
                                                               : tcw_pkg::ST_WRITE;
                            end
                        end
                        else
                        begin
                            state_next = tcw_pkg::ST_WRITE;
                        end
                    end
                    tcw_pkg::OP_CLEAR:
                    begin
                        cmd.idx_clear = 1'b1;
                        state_next    = tcw_pkg::ST_CLEAR_FILL;
                    end
                    tcw_pkg::OP_READ:
                    begin
                        cmd.read_issue = 1'b1;
                        state_next     = tcw_pkg::ST_READ;
                    end
                    default:
                    begin
                        state_next = tcw_pkg::ST_DONE;
                    end
                endcase
            end
            tcw_pkg::ST_SCROLL_RD:
            begin
                cmd.copy_read = 1'b1;
                state_next    = tcw_pkg::ST_SCROLL_WR;
            end
            tcw_pkg::ST_SCROLL_WR:
            begin
                cmd.copy_write = 1'b1;
                state_next = status.copy_last ? tcw_pkg::ST_SCROLL_FILL
                                              : tcw_pkg::ST_SCROLL_RD;
            end
            tcw_pkg::ST_SCROLL_FILL:
            begin
                cmd.fill_write = 1'b1;
                if (status.fill_last)
                begin
                    state_next = status.is_newline ? tcw_pkg::ST_DONE
                                                   : tcw_pkg::ST_WRITE;
                end
            end
            tcw_pkg::ST_CLEAR_FILL:
            begin
                cmd.fill_write = 1'b1;
                if (status.fill_last)
                begin
                    cmd.home   = 1'b1;
                    state_next = tcw_pkg::ST_DONE;
                end
            end
            tcw_pkg::ST_WRITE:
            begin
                cmd.put_write = 1'b1;
                state_next    = tcw_pkg::ST_DONE;
            end
            tcw_pkg::ST_READ:
            begin
                state_next = tcw_pkg::ST_DONE;
            end
            tcw_pkg::ST_DONE:
            begin
                done       = 1'b1;
                state_next = tcw_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tcw_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: sv/tcw_datapath.sv
module tcw_datapath (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  tcw_pkg::request_t                      request,
    input  logic                                   cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  tcw_pkg::dp_cmd_t                       cmd,
    output tcw_pkg::dp_status_t                    status,
    output tcw_pkg::result_t                       result
);

    logic [tcw_pkg::COL_W-1:0] x_reg;
    logic [tcw_pkg::ROW_W-1:0] y_reg;
    tcw_pkg::addr_t            idx_reg;
    logic [3:0]                fg_reg;
    logic [3:0]                bg_reg;
    logic                      hit_reg;

    tcw_pkg::op_t              op_reg;
    logic [7:0]                char_reg;
    tcw_pkg::addr_t            rd_addr_reg;
    logic [15:0]               rdata_reg;

    logic [15:0]               mem [tcw_pkg::CELLS];

    logic [7:0]                attr;
    tcw_pkg::addr_t            cur_addr;
    tcw_pkg::addr_t            req_addr;
    logic                      req_hit;
    logic                      we;
    tcw_pkg::addr_t            waddr;
    logic [15:0]               wdata;
    logic                      re;
    tcw_pkg::addr_t            raddr;

    assign attr     = {bg_reg, fg_reg};
    assign cur_addr = tcw_pkg::addr_t'(int'(y_reg) * tcw_pkg::COLUMNS + int'(x_reg));
    assign req_addr = tcw_pkg::addr_t'(int'(request.read_row) * tcw_pkg::COLUMNS
                                       + int'(request.read_col));
    assign req_hit  = (request.operation == tcw_pkg::OP_READ)
                   && (int'(request.read_row) < tcw_pkg::ROWS)
                   && (int'(request.read_col) < tcw_pkg::COLUMNS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg   <= '0;
            y_reg   <= '0;
            idx_reg <= '0;
            fg_reg  <= tcw_pkg::FG_RESET;
            bg_reg  <= tcw_pkg::BG_RESET;
            hit_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == tcw_pkg::REG_FOREGROUND)
                begin
                    fg_reg <= cfg_data;
                end
                else
                begin
                    bg_reg <= cfg_data;
                end
            end
            if (cmd.latch)
            begin
                hit_reg <= req_hit;
            end
            if (cmd.home)
            begin
                x_reg <= '0;
                y_reg <= '0;
            end
            else if (cmd.lf_advance)
            begin
                x_reg <= '0;
                y_reg <= y_reg + 1'b1;
            end
            else if (cmd.home_x)
            begin
                x_reg <= '0;
            end
            else if (cmd.put_write)
            begin
                x_reg <= x_reg + 1'b1;
            end
            if (cmd.idx_clear)
            begin
                idx_reg <= '0;
            end
            else if (cmd.copy_write || cmd.fill_write)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg      <= request.operation;
            char_reg    <= request.char_code;
            rd_addr_reg <= req_addr;
        end
    end

    // cell store: one write and one registered read per cycle
    assign we    = cmd.put_write || cmd.copy_write || cmd.fill_write;
    assign waddr = cmd.put_write ? cur_addr : idx_reg;
    assign re    = cmd.copy_read || cmd.read_issue;
    assign raddr = cmd.copy_read ? tcw_pkg::addr_t'(int'(idx_reg) + tcw_pkg::COLUMNS)
                                 : rd_addr_reg;

    always_comb
    begin
        if (cmd.put_write)
        begin
            wdata = {attr, char_reg};
        end
        else if (cmd.copy_write)
        begin
            wdata = rdata_reg;
        end
        else if (cmd.fill_reset)
        begin
            wdata = {tcw_pkg::RESET_ATTR, tcw_pkg::BLANK_CODE};
        end
        else
        begin
            wdata = {attr, tcw_pkg::BLANK_CODE};
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign status.operation  = op_reg;
    assign status.is_newline = (char_reg == tcw_pkg::NEWLINE_CODE);
    assign status.need_wrap  = (int'(x_reg) >= tcw_pkg::COLUMNS);
    assign status.last_row   = (int'(y_reg) == tcw_pkg::ROWS - 1);
    assign status.copy_last  = (int'(idx_reg) == tcw_pkg::CELLS - tcw_pkg::COLUMNS - 1);
    assign status.fill_last  = (int'(idx_reg) == tcw_pkg::CELLS - 1);

    assign result.cell_char  = hit_reg ? rdata_reg[7:0]  : 8'd0;
    assign result.cell_attr  = hit_reg ? rdata_reg[15:8] : 8'd0;
    assign result.cursor_row = tcw_pkg::row_field_t'(y_reg);
    assign result.cursor_col = tcw_pkg::col_field_t'(x_reg);

endmodule
